// File: src/cstc_pkg.sv
// Package for the C source token classifier: token class codes, fixed-width
// type words, queue sizes and result types. No dependencies.
package cstc_pkg;

    localparam int WordCharsDef  = 8;
    localparam int LengthBitsDef = 16;
    localparam int MaxRes        = 3;
    localparam int QueueDepth    = 4;

    localparam logic [3:0] CL_SPACE     = 4'd0;
    localparam logic [3:0] CL_COMMENT   = 4'd1;
    localparam logic [3:0] CL_DIRECTIVE = 4'd2;
    localparam logic [3:0] CL_KEYWORD   = 4'd3;
    localparam logic [3:0] CL_TYPE      = 4'd4;
    localparam logic [3:0] CL_NUMBER    = 4'd5;
    localparam logic [3:0] CL_STRING    = 4'd6;
    localparam logic [3:0] CL_MACRO     = 4'd7;
    localparam logic [3:0] CL_IDENT     = 4'd8;
    localparam logic [3:0] CL_PUNCT     = 4'd9;
    localparam logic [3:0] CL_BREAK     = 4'd10;
    localparam logic [3:0] CL_NONE      = 4'd15;

    // Fixed-width unsigned type words, first byte in the top byte.
    localparam logic [63:0] TyWordU16 = {"uint", "16_t"};
    localparam logic [63:0] TyWordU32 = {"uint", "32_t"};
    localparam logic [63:0] TyWordU64 = {"uint", "64_t"};

    // One result as it travels from the classifier to the output queue.
    typedef struct packed {
        logic [3:0]  cls;
        logic [15:0] len;
        logic        sat;
        logic        last;
        logic        tend;
    } t_res;

    // Up to three results produced by one byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_res [MaxRes-1:0] res;
    } t_bundle;

endpackage

// File: src/c_source_token_classifier.sv
// Top level of the C source token classifier: byte stream in, token stream
// out. Instantiates cstc_front and cstc_back; uses cstc_pkg.
//
//  channel | dir | tdata (low bit up)                  | tuser / tlast
//  s_axis  | in  | char_code[7:0]                      | tlast = end_of_text
//  m_axis  | out | token_class[3:0], token_length[19:4],| tuser[0] length_saturated,
//          |     | zero fill [23:20]                   | tuser[1] run_last, tlast text_end
//
// One byte is taken every cycle while the result queue has room; the whole
// classification of a byte, word matching included, is done in that cycle.
// Results leave one per beat, so a byte making two or three tokens takes that
// many output beats; the four-bundle queue absorbs the difference.
// Reset is synchronous, active low; it returns to line start with nothing
// pending. A stall on m_axis fills the queue, then drops s_axis_tready.
module c_source_token_classifier
    import cstc_pkg::*;
#(
    parameter int WORD_CHARS  = WordCharsDef,
    parameter int LENGTH_BITS = LengthBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // token_class, token_length, zero fill
    output logic [1:0]  m_axis_tuser,   // length_saturated, run_last
    output logic        m_axis_tlast    // text_end
);

    t_bundle w_bundle;
    t_res    w_res;
    logic    w_take;

    // Accept a byte only when the queue can hold its bundle.
    assign w_take = s_axis_tvalid && s_axis_tready;

    cstc_front #(
        .WORD_CHARS (WORD_CHARS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_char  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .o_bundle(w_bundle)
    );

    cstc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_bundle(w_bundle),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (w_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, w_res.len, w_res.cls};
    assign m_axis_tuser = {w_res.last, w_res.sat};
    assign m_axis_tlast = w_res.tend;

endmodule

// File: src/cstc_front.sv
// Front part: accepts one byte a cycle while i_valid is set, tracks the line and token state and
// produces the results for that byte as one bundle. Uses cstc_pkg.
module cstc_front
    import cstc_pkg::*;
#(
    parameter int WORD_CHARS  = WordCharsDef,
    parameter int LENGTH_BITS = LengthBitsDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_end,
    output t_bundle       o_bundle
);

    localparam int WIDX = $clog2(WORD_CHARS);
    localparam logic [LENGTH_BITS-1:0] LenCap =
        (LENGTH_BITS >= 16) ? LENGTH_BITS'(16'hFFFF) : {LENGTH_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_LEAD, PH_CODE, PH_HASH, PH_DIRECTIVE, PH_PREPROC, PH_COMMENT
    } t_phase;
    typedef enum logic [1:0] {NUM_INT, NUM_ZERO, NUM_FRAC, NUM_HEX} t_num;

    t_phase r_phase, n_phase;
    logic [3:0] r_pcls, n_pcls;
    logic [LENGTH_BITS-1:0] r_plen, n_plen;
    logic r_sat, n_sat;
    logic [7:0] r_word [WORD_CHARS];
    logic [1:0] r_shape, n_shape;
    logic r_expm, n_expm;
    t_num r_num, n_num;
    logic [7:0] r_quote, n_quote;
    logic r_esc, n_esc;
    logic r_slash, n_slash;
    logic           w_we;
    logic [WIDX-1:0] w_widx;
    logic [7:0]     w_wdat;

    // word_buffer contents, after writes done this byte, for classifying
    logic [7:0] v_word [WORD_CHARS];

    function automatic logic f_space(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13;
    endfunction
    function automatic logic f_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction
    function automatic logic f_upper(input logic [7:0] c);
        return c >= 8'd65 && c <= 8'd90;
    endfunction
    function automatic logic f_lower(input logic [7:0] c);
        return c >= 8'd97 && c <= 8'd122;
    endfunction
    function automatic logic f_wstart(input logic [7:0] c);
        return f_upper(c) || f_lower(c) || c == 8'd95;
    endfunction
    function automatic logic f_wpart(input logic [7:0] c);
        return f_wstart(c) || f_digit(c);
    endfunction
    function automatic logic f_hex(input logic [7:0] c);
        return f_digit(c) || (c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102);
    endfunction

    // Word match against a constant string of up to eight bytes, right-aligned
    // in s, so that its first byte sits in byte n-1 of s.
    function automatic logic f_eq(input logic [63:0] s, input int n,
                                  input logic [LENGTH_BITS-1:0] len,
                                  input logic [7:0] w [WORD_CHARS]);
        logic ok;
        ok = (len == LENGTH_BITS'(n)) && (n <= WORD_CHARS);
        for (int i = 0; i < 8; i++) begin
            if (i < n && i < WORD_CHARS) begin
                if (w[i] != s[8*(n-1-i) +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Working variables of the per-byte sequence
    logic [3:0]  v_pcls;
    logic [LENGTH_BITS-1:0] v_plen;
    logic        v_sat;
    logic [1:0]  v_shape;
    logic        v_expm;
    t_num        v_num;
    logic [7:0]  v_quote;
    logic        v_esc, v_slash;
    t_phase      v_phase;
    t_bundle     v_b;
    logic        v_kw, v_ty, v_shp;
    logic [3:0]  v_cls;

    always_comb begin
        v_pcls = r_pcls; v_plen = r_plen; v_sat = r_sat; v_shape = r_shape;
        v_expm = r_expm; v_num = r_num; v_quote = r_quote; v_esc = r_esc;
        v_slash = r_slash; v_phase = r_phase; v_b = '0;
        v_kw = 1'b0; v_ty = 1'b0; v_shp = 1'b0;
        v_cls = CL_NONE;
        w_we = 1'b0; w_widx = '0; w_wdat = i_char;
        for (int i = 0; i < WORD_CHARS; i++) v_word[i] = r_word[i];

        // The per-byte sequence, through the helper steps below.
        step();
        n_pcls = v_pcls; n_plen = v_plen; n_sat = v_sat; n_shape = v_shape;
        n_expm = v_expm; n_num = v_num; n_quote = v_quote; n_esc = v_esc;
        n_slash = v_slash; n_phase = v_phase;
    end

    function automatic void grow();
        if (v_plen < LenCap) v_plen = v_plen + 1'b1;
        else v_sat = 1'b1;
    endfunction
    function automatic void start(input logic [3:0] c);
        v_pcls = c; v_plen = '0; v_sat = 1'b0; v_shape = 2'b00;
    endfunction
    function automatic void emit(input logic [3:0] c,
                                 input logic [LENGTH_BITS-1:0] l, input logic s);
        if (v_b.cnt < 2'(MaxRes)) begin
            v_b.res[v_b.cnt].cls = c;
            v_b.res[v_b.cnt].len = 16'(l);
            v_b.res[v_b.cnt].sat = s;
            v_b.cnt = v_b.cnt + 2'd1;
        end
    endfunction
    function automatic void word_add(input logic [7:0] c);
        if (v_plen < LENGTH_BITS'(WORD_CHARS)) begin
            w_we = 1'b1;
            w_widx = WIDX'(v_plen);
            v_word[WIDX'(v_plen)] = c;
        end
        if (f_upper(c)) v_shape[0] = 1'b1;
        else if (f_lower(c)) v_shape[1] = 1'b1;
        grow();
    endfunction
    function automatic void flush_pending();
        v_cls = v_pcls;
        if (v_cls != CL_NONE) begin
            if (v_cls == CL_IDENT) begin
                v_shp = (v_shape == 2'b01);
                v_kw = f_eq("static", 6, v_plen, v_word) || f_eq("const", 5, v_plen, v_word)
                    || f_eq("unsigned", 8, v_plen, v_word) || f_eq("signed", 6, v_plen, v_word)
                    || f_eq("void", 4, v_plen, v_word) || f_eq("char", 4, v_plen, v_word)
                    || f_eq("int", 3, v_plen, v_word) || f_eq("short", 5, v_plen, v_word)
                    || f_eq("long", 4, v_plen, v_word) || f_eq("float", 5, v_plen, v_word)
                    || f_eq("double", 6, v_plen, v_word)
                    || f_eq("volatile", 8, v_plen, v_word)
                    || f_eq("extern", 6, v_plen, v_word);
                v_ty = f_eq("uint8_t", 7, v_plen, v_word) || f_eq(TyWordU16, 8, v_plen, v_word)
                    || f_eq(TyWordU32, 8, v_plen, v_word) || f_eq(TyWordU64, 8, v_plen, v_word)
                    || f_eq("int8_t", 6, v_plen, v_word) || f_eq("int16_t", 7, v_plen, v_word)
                    || f_eq("int32_t", 7, v_plen, v_word) || f_eq("int64_t", 7, v_plen, v_word)
                    || f_eq("size_t", 6, v_plen, v_word) || f_eq("PROGMEM", 7, v_plen, v_word);
                if (v_phase == PH_PREPROC) begin
                    if (v_expm) begin v_expm = 1'b0; v_cls = CL_MACRO; end
                    else if (v_shp) v_cls = CL_MACRO;
                    else if (v_kw) v_cls = CL_KEYWORD;
                    else if (v_ty) v_cls = CL_TYPE;
                    else v_cls = CL_IDENT;
                end else begin
                    if (v_kw) v_cls = CL_KEYWORD;
                    else if (v_ty) v_cls = CL_TYPE;
                    else if (v_shp) v_cls = CL_MACRO;
                    else v_cls = CL_IDENT;
                end
            end else if (v_cls == CL_DIRECTIVE) begin
                v_expm = f_eq("define", 6, v_plen, v_word);
            end
            emit(v_cls, v_plen, v_sat);
            v_pcls = CL_NONE;
        end
    endfunction
    function automatic void flush_slash();
        if (v_slash) begin
            emit(CL_PUNCT, LENGTH_BITS'(1), 1'b0);
            v_slash = 1'b0;
        end
    endfunction
    function automatic logic num_cont(input logic [7:0] c);
        case (v_num)
            NUM_ZERO: begin
                if (c == 8'd120 || c == 8'd88) begin v_num = NUM_HEX; return 1'b1; end
                if (f_digit(c)) begin v_num = NUM_INT; return 1'b1; end
                if (c == 8'd46) begin v_num = NUM_FRAC; return 1'b1; end
                return 1'b0;
            end
            NUM_INT: begin
                if (f_digit(c)) return 1'b1;
                if (c == 8'd46) begin v_num = NUM_FRAC; return 1'b1; end
                return 1'b0;
            end
            NUM_FRAC: return f_digit(c);
            default:  return f_hex(c);
        endcase
    endfunction
    function automatic void body_char(input logic [7:0] c);
        logic pre;
        logic fin;
        pre = (v_phase == PH_PREPROC);
        fin = 1'b0;
        case (v_pcls)
            CL_STRING: begin
                grow();
                if (v_esc) v_esc = 1'b0;
                else if (c == 8'd92) v_esc = 1'b1;
                else if (c == v_quote) flush_pending();
                fin = 1'b1;
            end
            CL_NUMBER: begin
                if (num_cont(c)) begin grow(); fin = 1'b1; end
                else flush_pending();
            end
            CL_IDENT: begin
                if (f_wpart(c)) begin word_add(c); fin = 1'b1; end
                else flush_pending();
            end
            CL_SPACE: begin
                if (f_space(c)) begin grow(); fin = 1'b1; end
                else flush_pending();
            end
            default: ;
        endcase
        if (!fin && v_slash) begin
            if (c == 8'd47) begin
                v_slash = 1'b0;
                v_phase = PH_COMMENT;
                start(CL_COMMENT);
                grow();
                grow();
                fin = 1'b1;
            end else begin
                flush_slash();
            end
        end
        if (!fin) begin
            if (f_space(c)) begin
                start(CL_SPACE); grow();
            end else if (c == 8'd34 || c == 8'd39) begin
                start(CL_STRING); v_quote = c; v_esc = 1'b0; grow();
            end else if (f_digit(c)) begin
                start(CL_NUMBER);
                v_num = (c == 8'd48) ? NUM_ZERO : NUM_INT;
                grow();
            end else if (f_wstart(c)) begin
                start(CL_IDENT); word_add(c);
            end else if (c == 8'd47 && !pre) begin
                v_slash = 1'b1;
            end else begin
                emit(CL_PUNCT, LENGTH_BITS'(1), 1'b0);
            end
        end
    endfunction
    function automatic void step();
        if (i_char == 8'd10) begin
            flush_pending();
            flush_slash();
            emit(CL_BREAK, '0, 1'b0);
            v_phase = PH_LEAD; v_expm = 1'b0; v_esc = 1'b0;
        end else begin
            case (v_phase)
                PH_LEAD: begin
                    if (v_slash) begin
                        if (i_char == 8'd47) begin
                            v_slash = 1'b0;
                            if (v_pcls != CL_SPACE) start(CL_COMMENT);
                            v_pcls = CL_COMMENT;
                            grow(); grow();
                            v_phase = PH_COMMENT;
                        end else begin
                            flush_pending(); flush_slash();
                            v_phase = PH_CODE;
                            body_char(i_char);
                        end
                    end else if (f_space(i_char)) begin
                        if (v_pcls != CL_SPACE) start(CL_SPACE);
                        grow();
                    end else if (i_char == 8'd35) begin
                        flush_pending();
                        emit(CL_PUNCT, LENGTH_BITS'(1), 1'b0);
                        v_phase = PH_HASH;
                    end else if (i_char == 8'd47) begin
                        v_slash = 1'b1;
                    end else begin
                        flush_pending();
                        v_phase = PH_CODE;
                        body_char(i_char);
                    end
                end
                PH_HASH: begin
                    if (f_space(i_char)) begin
                        if (v_pcls != CL_SPACE) start(CL_SPACE);
                        grow();
                    end else if (f_wpart(i_char)) begin
                        flush_pending();
                        start(CL_DIRECTIVE);
                        word_add(i_char);
                        v_phase = PH_DIRECTIVE;
                    end else begin
                        flush_pending();
                        v_expm = 1'b0;
                        v_phase = PH_PREPROC;
                        body_char(i_char);
                    end
                end
                PH_DIRECTIVE: begin
                    if (f_wpart(i_char)) word_add(i_char);
                    else begin
                        flush_pending();
                        v_phase = PH_PREPROC;
                        body_char(i_char);
                    end
                end
                PH_COMMENT: grow();
                default: body_char(i_char);
            endcase
        end
        if (i_end) begin
            flush_pending();
            flush_slash();
            v_phase = PH_LEAD; v_pcls = CL_NONE; v_plen = '0; v_sat = 1'b0;
            v_shape = 2'b00; v_expm = 1'b0; v_num = NUM_INT; v_quote = '0;
            v_esc = 1'b0; v_slash = 1'b0;
        end
        if (v_b.cnt != 2'd0) begin
            v_b.res[v_b.cnt - 2'd1].last = 1'b1;
            v_b.res[v_b.cnt - 2'd1].tend = i_end;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_pcls  <= CL_NONE;
            r_plen  <= '0;
            r_sat   <= 1'b0;
            r_shape <= 2'b00;
            r_expm  <= 1'b0;
            r_num   <= NUM_INT;
            r_quote <= '0;
            r_esc   <= 1'b0;
            r_slash <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_pcls  <= n_pcls;
            r_plen  <= n_plen;
            r_sat   <= n_sat;
            r_shape <= n_shape;
            r_expm  <= n_expm;
            r_num   <= n_num;
            r_quote <= n_quote;
            r_esc   <= n_esc;
            r_slash <= n_slash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_we) r_word[w_widx] <= w_wdat;
    end

    assign o_bundle = v_b;

endmodule

// File: src/cstc_back.sv
// Back part: a short queue of result bundles and an unpacker that sends one
// result per beat. Uses cstc_pkg.
module cstc_back
    import cstc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_room,
    output logic    o_valid,
    output t_res    o_res,
    input  logic    i_ready
);

    localparam int PW = $clog2(QueueDepth);

    t_bundle r_q [QueueDepth];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic [1:0]    r_sub;
    logic          w_pop_beat, w_pop_bundle, w_push;

    // Bundles with no result are dropped at the door.
    assign w_push       = i_push && (i_bundle.cnt != 2'd0);
    assign o_room       = (r_cnt != (PW+1)'(QueueDepth));
    assign o_valid      = (r_cnt != '0);
    assign o_res        = r_q[r_rp].res[r_sub];
    assign w_pop_beat   = o_valid && i_ready;
    assign w_pop_bundle = w_pop_beat && (r_sub + 2'd1 == r_q[r_rp].cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sub <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop_bundle) begin
                r_rp  <= r_rp + 1'b1;
                r_sub <= '0;
            end else if (w_pop_beat) begin
                r_sub <= r_sub + 2'd1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop_bundle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_bundle;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QueueDepth))
        else $error("bundle queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_sub < r_q[r_rp].cnt))
        else $error("unpacker index past bundle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_sub == $past(r_sub)))
        else $error("unpacker advanced while stalled");

endmodule
